@@ hdl/tlb_pkg.sv @@
// ----------------------------------------------------------------------------
// TLB translate package
// Shared types, widths and a helper function for the TLB and page-table
// translation block.
// ----------------------------------------------------------------------------
`default_nettype none

package tlb_pkg;

  localparam int unsigned PAGE_W       = 8;
  localparam int unsigned FRAME_W      = 8;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned NEXT_FRAME_W = 9;
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_TDATA_W  = 40;
  localparam int unsigned OUT_TUSER_W  = 2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } tlb_state_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic commit;
  } tlb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } tlb_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc16(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/tlb_page_table_translate.sv @@
// A result is registered in the output register when the lookup state commits
// it, once the output register is free. A new word is accepted only after the
// registered page-table read and the TLB, table and counter update of the last
// word. Reset: synchronous, active low; afterwards a clearing pass sweeps the
// whole page-table memory with in_tready low.
// ----------------------------------------------------------------------------
// TLB and page-table translation, top level
// Translates page numbers through a FIFO-replaced TLB backed by a demand-paged
// page table, counting hits and faults with saturating counters.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_page_table_translate #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGES       = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // page_number[7:0]
  input  wire logic [tlb_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // frame_number[7:0], hit_total[23:8], fault_total[39:24]
  output logic [tlb_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // tlb_hit[0], page_fault[1]
  output logic [tlb_pkg::OUT_TUSER_W-1:0]     out_tuser
);

  tlb_pkg::tlb_cmd_t  cmd;
  tlb_pkg::tlb_stat_t stat;

  tlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlb_dp #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGES       (PAGES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

@@ hdl/tlb_ctrl.sv @@
// ----------------------------------------------------------------------------
// TLB translate controller
// Sequences the page-table clearing pass, word acceptance and the lookup and
// update step that commits one result.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire tlb_pkg::tlb_stat_t stat,
  output tlb_pkg::tlb_cmd_t       cmd
);

  tlb_pkg::tlb_state_t state_r;
  tlb_pkg::tlb_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlb_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlb_pkg::ST_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt = tlb_pkg::ST_IDLE;
        end
      end
      tlb_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = tlb_pkg::ST_LOOK;
        end
      end
      tlb_pkg::ST_LOOK: begin
        if (stat.out_free) begin
          state_nxt = tlb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tlb_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd.clr    = 1'b0;
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      tlb_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      tlb_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      tlb_pkg::ST_LOOK: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/tlb_dp.sv @@
// ----------------------------------------------------------------------------
// TLB translate datapath
// Holds the TLB entries, the page-table memory, the frame allocator, the
// saturating counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_dp #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGES       = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire tlb_pkg::tlb_cmd_t                  cmd,
  output tlb_pkg::tlb_stat_t                      stat,
  input  wire logic [tlb_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [tlb_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic [tlb_pkg::OUT_TUSER_W-1:0]         out_tuser
);

  localparam int unsigned PTR_W   = $clog2(TLB_ENTRIES);
  localparam int unsigned IDX_W   = $clog2(PAGES);
  localparam int unsigned LUT_N   = 1 << tlb_pkg::PAGE_W;
  localparam int unsigned ENTRY_W = tlb_pkg::FRAME_W + 1;

  logic [IDX_W-1:0] idx_lut [LUT_N];

  for (genvar g = 0; g < LUT_N; g++) begin : g_idx
    localparam int unsigned RED = g % PAGES;
    assign idx_lut[g] = IDX_W'(RED);
  end

  logic [tlb_pkg::PAGE_W-1:0]      tlb_page_r  [TLB_ENTRIES];
  logic [tlb_pkg::FRAME_W-1:0]     tlb_frame_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]          tlb_valid_r;
  logic [PTR_W-1:0]                fifo_ptr_r;
  logic [ENTRY_W-1:0]              pt_mem [PAGES];
  logic [ENTRY_W-1:0]              pt_rd_r;
  logic [IDX_W-1:0]                clr_cnt_r;
  logic [tlb_pkg::PAGE_W-1:0]      page_r;
  logic [IDX_W-1:0]                idx_r;
  logic [tlb_pkg::NEXT_FRAME_W-1:0] next_frame_r;
  logic [tlb_pkg::CNT_W-1:0]       hit_cnt_r;
  logic [tlb_pkg::CNT_W-1:0]       hit_cnt_nxt;
  logic [tlb_pkg::CNT_W-1:0]       fault_cnt_r;
  logic [tlb_pkg::CNT_W-1:0]       fault_cnt_nxt;
  logic                            out_valid_r;
  logic [tlb_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [tlb_pkg::OUT_TUSER_W-1:0] out_tuser_r;

  logic                            hit;
  logic [tlb_pkg::FRAME_W-1:0]     hit_frame;
  logic                            fault;
  logic [tlb_pkg::FRAME_W-1:0]     frame;
  logic [IDX_W-1:0]                rd_addr;
  logic                            wr_en;
  logic [IDX_W-1:0]                wr_addr;
  logic [ENTRY_W-1:0]              wr_data;

  // The lowest-numbered matching entry wins.
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_r[i] && (tlb_page_r[i] == page_r)) begin
        hit       = 1'b1;
        hit_frame = tlb_frame_r[i];
      end
    end
  end

  always_comb begin
    fault         = !hit && !pt_rd_r[ENTRY_W-1];
    frame         = hit ? hit_frame :
                    (pt_rd_r[ENTRY_W-1] ? pt_rd_r[tlb_pkg::FRAME_W-1:0] :
                     next_frame_r[tlb_pkg::FRAME_W-1:0]);
    hit_cnt_nxt   = hit ? tlb_pkg::sat_inc16(hit_cnt_r) : hit_cnt_r;
    fault_cnt_nxt = fault ? tlb_pkg::sat_inc16(fault_cnt_r) : fault_cnt_r;
  end

  assign rd_addr = idx_lut[in_tdata[tlb_pkg::PAGE_W-1:0]];
  assign wr_en   = cmd.clr || (cmd.commit && fault);
  assign wr_addr = cmd.clr ? clr_cnt_r : idx_r;
  assign wr_data = cmd.clr ? '0 : {1'b1, next_frame_r[tlb_pkg::FRAME_W-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pt_mem[wr_addr] <= wr_data;
    end
    if (cmd.accept) begin
      pt_rd_r <= pt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      page_r <= in_tdata[tlb_pkg::PAGE_W-1:0];
      idx_r  <= rd_addr;
    end
    if (cmd.commit && !hit) begin
      tlb_page_r[fifo_ptr_r]  <= page_r;
      tlb_frame_r[fifo_ptr_r] <= frame;
    end
    if (cmd.commit) begin
      out_tdata_r <= {fault_cnt_nxt, hit_cnt_nxt, frame};
      out_tuser_r <= {fault, hit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlb_valid_r  <= '0;
      fifo_ptr_r   <= '0;
      clr_cnt_r    <= '0;
      next_frame_r <= '0;
      hit_cnt_r    <= '0;
      fault_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        hit_cnt_r   <= hit_cnt_nxt;
        fault_cnt_r <= fault_cnt_nxt;
        if (!hit) begin
          tlb_valid_r[fifo_ptr_r] <= 1'b1;
          fifo_ptr_r <= (fifo_ptr_r == PTR_W'(TLB_ENTRIES - 1)) ? '0 :
                        fifo_ptr_r + 1'b1;
        end
        if (fault) begin
          next_frame_r <= next_frame_r + 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat = '{clr_last: (clr_cnt_r == IDX_W'(PAGES - 1)),
                  out_free: (!out_valid_r || out_tready)};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

@@ hdl/tlb_checker.sv @@
// ----------------------------------------------------------------------------
// TLB translate port checker
// Watches the ports of the translation block and flags behaviour that the
// design must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [tlb_pkg::IN_TDATA_W-1:0] in_tdata,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [tlb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [tlb_pkg::OUT_TUSER_W-1:0] out_tuser
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("ports not quiet after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while one is in work");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  a_fault_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && (out_tdata[39:24] != 16'd0))
    else $error("fault flagged with a hit or a zero fault total");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[23:8] != 16'd0))
    else $error("hit flagged with a zero hit total");

endmodule

bind tlb_page_table_translate tlb_checker u_tlb_checker (.*);

`default_nettype wire

@@ tb/tlb_page_table_translate_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB and page-table translation testbench
// Streams page numbers into the translation block and checks every result
// word against a behavioural TLB with FIFO replacement and a demand-paged
// page table. Directed words come first, then random words that mostly reuse
// recent pages, under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tlb_page_table_translate_tb;

  localparam int unsigned TLB_SLOTS  = 16;
  localparam int unsigned PAGE_COUNT = 256;
  localparam int unsigned RANDOM_N   = 1080;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned MAX_SHOWN  = 10;

  typedef struct packed {
    logic [tlb_pkg::FRAME_W-1:0] frame;
    logic                        hit;
    logic                        fault;
    logic [tlb_pkg::CNT_W-1:0]   hit_total;
    logic [tlb_pkg::CNT_W-1:0]   fault_total;
  } xlat_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [tlb_pkg::IN_TDATA_W-1:0]   in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [tlb_pkg::OUT_TDATA_W-1:0]  out_tdata;
  logic [tlb_pkg::OUT_TUSER_W-1:0]  out_tuser;

  // Behavioural copy of the translation state.
  bit                               slot_ok [TLB_SLOTS];
  logic [tlb_pkg::PAGE_W-1:0]       slot_vpn [TLB_SLOTS];
  logic [tlb_pkg::FRAME_W-1:0]      slot_pfn [TLB_SLOTS];
  int unsigned                      victim;
  bit                               pte_ok [PAGE_COUNT];
  logic [tlb_pkg::FRAME_W-1:0]      pte_pfn [PAGE_COUNT];
  logic [tlb_pkg::NEXT_FRAME_W-1:0] free_frame;
  logic [tlb_pkg::CNT_W-1:0]        hits;
  logic [tlb_pkg::CNT_W-1:0]        faults;

  logic [tlb_pkg::PAGE_W-1:0]       page_queue [$];
  xlat_t                            translations [$];
  xlat_t                            want;
  xlat_t                            got;
  int unsigned                      n_items;
  int unsigned                      n_sent;
  int unsigned                      n_checked;
  int unsigned                      errors;
  int unsigned                      cycles;
  int unsigned                      tx_idle;
  int unsigned                      rx_idle;

  tlb_page_table_translate #(
    .TLB_ENTRIES(TLB_SLOTS),
    .PAGES      (PAGE_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic logic [tlb_pkg::CNT_W-1:0] bump(input logic [tlb_pkg::CNT_W-1:0] v);
    return (v == {tlb_pkg::CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic xlat_t translate_page(input logic [tlb_pkg::PAGE_W-1:0] vpn);
    xlat_t       r;
    bit          found;
    int unsigned idx;
    r = '0;
    found = 1'b0;
    for (int i = 0; i < TLB_SLOTS; i++) begin
      if (!found && slot_ok[i] && slot_vpn[i] == vpn) begin
        found = 1'b1;
        r.frame = slot_pfn[i];
      end
    end
    if (found) begin
      r.hit = 1'b1;
      hits = bump(hits);
    end else begin
      idx = vpn % PAGE_COUNT;
      if (pte_ok[idx]) begin
        r.frame = pte_pfn[idx];
      end else begin
        r.fault = 1'b1;
        r.frame = free_frame[tlb_pkg::FRAME_W-1:0];
        pte_pfn[idx] = r.frame;
        pte_ok[idx] = 1'b1;
        free_frame = free_frame + 1'b1;
        faults = bump(faults);
      end
      slot_vpn[victim] = vpn;
      slot_pfn[victim] = r.frame;
      slot_ok[victim] = 1'b1;
      victim = (victim + 1) % TLB_SLOTS;
    end
    r.hit_total = hits;
    r.fault_total = faults;
    return r;
  endfunction

  // Sender and receiver. Idling runs in three phases over the stimulus.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        n_sent++;
      end
      if (n_sent < n_items / 3) begin
        tx_idle = 33;
        rx_idle = 57;
      end else if (n_sent < 2 * n_items / 3) begin
        tx_idle = 57;
        rx_idle = 33;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if (!in_tvalid || in_tready) begin
        if (page_queue.size() != 0 && $urandom_range(99) >= tx_idle &&
            !((n_sent == 23 || n_sent == 600) && n_checked < n_sent)) begin
          in_tvalid <= 1'b1;
          in_tdata <= page_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Monitor: predicts on each accepted input word, checks each result word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        translations.push_back(translate_page(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        n_checked++;
        got.frame = out_tdata[7:0];
        got.hit_total = out_tdata[23:8];
        got.fault_total = out_tdata[39:24];
        got.hit = out_tuser[0];
        got.fault = out_tuser[1];
        if (translations.size() == 0) begin
          if (errors < MAX_SHOWN) begin
            $display("unexpected result word: frame %0d hit %0b fault %0b hits %0d faults %0d",
                     got.frame, got.hit, got.fault, got.hit_total, got.fault_total);
          end
          errors++;
        end else begin
          want = translations.pop_front();
          if (got.frame != want.frame || got.hit != want.hit || got.fault != want.fault ||
              got.hit_total != want.hit_total || got.fault_total != want.fault_total) begin
            if (errors < MAX_SHOWN) begin
              $display("mismatch on word %0d: frame %0d/%0d hit %0b/%0b fault %0b/%0b",
                       n_checked, want.frame, got.frame, want.hit, got.hit,
                       want.fault, got.fault);
              $display("  hits %0d/%0d faults %0d/%0d (expected/actual)",
                       want.hit_total, got.hit_total, want.fault_total, got.fault_total);
            end
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [tlb_pkg::PAGE_W-1:0] pg;
    logic [tlb_pkg::PAGE_W-1:0] recent [$];
    int unsigned                r;
    victim = 0;
    free_frame = '0;
    hits = '0;
    faults = '0;
    n_sent = 0;
    n_checked = 0;
    errors = 0;
    cycles = 0;
    tx_idle = 0;
    rx_idle = 0;
    pg = '0;
    foreach (slot_ok[i]) slot_ok[i] = 1'b0;
    foreach (pte_ok[i]) pte_ok[i] = 1'b0;

    // Extremes and repeats, then enough new pages to wrap the FIFO, so that
    // evicted pages come back as misses that find the page table mapped.
    page_queue = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd170, 8'd85, 8'd170,
                   8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128,
                   8'd127, 8'd191, 8'd223, 8'd239, 8'd254, 8'd0, 8'd255, 8'd1};

    // Random words mostly revisit a window of recent pages larger than the
    // TLB, giving a mix of hits, mapped misses and faults.
    for (int k = 0; k < RANDOM_N; k++) begin
      r = $urandom_range(99);
      if (r < 55 && recent.size() != 0) begin
        pg = recent[$urandom_range(recent.size() - 1)];
      end else if (r < 65) begin
        pg = pg + 1'b1;
      end else begin
        pg = tlb_pkg::PAGE_W'($urandom_range(255));
      end
      page_queue.push_back(pg);
      recent.push_back(pg);
      if (recent.size() > 24) begin
        void'(recent.pop_front());
      end
    end
    n_items = page_queue.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (page_queue.size() != 0 || in_tvalid || translations.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
